// File: hw/rtl/phs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_pkg
// Shared constants and types for the pose history stabilizer.
// ----------------------------------------------------------------------------
package phs_pkg;

    // parameter defaults
    localparam int DEF_MAX_HISTORY = 16;
    localparam int DEF_FRAC_BITS   = 16;

    // fixed field widths
    localparam int DATA_W     = 32;
    localparam int LIMIT_W    = 5;
    localparam int THR_W      = 31;
    localparam int FILL_W     = 5;
    localparam int CNT8_W     = 8;
    localparam int POSE_WORDS = 16;
    localparam int ELEM_W     = 4;

    // row that closes a frame
    localparam logic [1:0] ROW_LAST = 2'd3;
    localparam logic [ELEM_W-1:0] ELEM_LAST = 4'd15;

    // configuration register indexes
    localparam logic REG_HISTORY_LIMIT  = 1'b0;
    localparam logic REG_JUMP_THRESHOLD = 1'b1;

    // frame sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SQ,
        ST_SQ_ACC,
        ST_DECIDE,
        ST_PUSH,
        ST_TRIM,
        ST_WDEN,
        ST_CLEAR,
        ST_DONE
    } phs_state_t;

endpackage

// File: hw/rtl/pose_history_stabilizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_history_stabilizer
// Pose smoothing with an outlier gate over a history of accepted poses.
// ----------------------------------------------------------------------------
// Usage: one 4x4 pose per frame enters on the s_ stream as four row items
// (tuser carries row index and tracked flag). Rows 0..2 are only stored.
// The row 3 item starts the frame step; afterwards four result items leave
// on the m_ stream, rows 0..3, tlast on row 3, each with the history fill.
// A frame step makes a distance pass, writes the pose to the history if it
// passes the gate and then makes a weighted averaging pass; its length is
// set by the single history RAM read port and the shared bit-serial divider.
// An untracked frame or the first pose skips both passes. s_tready is high
// only between frame steps, so one frame is worked on at a time.
// Results sit in an output copy: the next frame's rows are taken while the
// receiver stalls, and a new frame result waits until the old one drained.
// Reset empties the history, clears counters and the held pose to zero and
// loads history_limit 8 and jump_threshold 3.0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pose_history_stabilizer #(
    parameter int MAX_HISTORY = phs_pkg::DEF_MAX_HISTORY,
    parameter int FRAC_BITS   = phs_pkg::DEF_FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    // input rows
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // elem_c0, elem_c1, elem_c2, elem_c3
    input  logic [2:0]    s_tuser,   // row_index[1:0], tracked
    // result rows
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,   // out_c0, out_c1, out_c2, out_c3, history_fill, pad
    output logic [1:0]    m_tuser,   // out_row
    output logic          m_tlast,   // last_row
    // configuration
    input  logic          cfg_wr_en,
    input  logic          cfg_index,
    input  logic [30:0]   cfg_data
);

    import phs_pkg::*;

    localparam int SW    = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int CW    = $clog2(MAX_HISTORY + 1);
    localparam int WDW   = 2 * CW;
    localparam int MW    = WDW + 1;
    localparam int PW    = DATA_W + CW + 1;
    localparam int AW    = DATA_W + 2 * CW + 1;
    localparam int NW    = AW + 2;
    localparam int DEPTH = MAX_HISTORY * POSE_WORDS;
    localparam int AM    = $clog2(DEPTH);

    phs_state_t state_reg;
    phs_state_t state_next;

    // configuration and derived constants
    logic [LIMIT_W-1:0] limit_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [CW-1:0]      lim_reg;
    logic [61:0]        thr2_reg;

    // history bookkeeping
    logic [CW-1:0]      count_reg;
    logic [SW-1:0]      head_reg;
    logic [CNT8_W-1:0]  lost_reg;
    logic [CNT8_W-1:0]  jump_reg;

    // sequencing
    logic [ELEM_W-1:0]  e_reg;
    logic [CW-1:0]      i_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic [CW-1:0]      w1_reg;
    logic               wavg_reg;
    logic               first_reg;
    logic               popped_reg;
    logic               out_busy_reg;
    logic [1:0]         out_row_reg;

    // payload
    logic [DATA_W-1:0]    incoming_reg [POSE_WORDS];
    logic [DATA_W-1:0]    held_reg     [POSE_WORDS];
    logic [DATA_W-1:0]    out_pose_reg [POSE_WORDS];
    logic [FILL_W-1:0]    fill_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] sacc_reg;
    logic [DATA_W-1:0]    mean_reg;
    logic [63:0]          sq_reg;
    logic [63:0]          dacc_reg;
    logic [WDW-1:0]       wden_reg;

    // memory and divider hookup
    logic              mem_we;
    logic [AM-1:0]     mem_waddr;
    logic [AM-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic signed [NW-1:0] div_num;
    logic [MW-1:0]     div_den;
    logic signed [NW-1:0] div_quot;

    logic              s_acc;
    logic              m_acc;
    logic [1:0]        s_row;
    logic              s_tracked;
    logic              issue;
    logic [SW-1:0]     rd_slot;
    logic [SW-1:0]     push_slot;
    logic [WDW-1:0]    den_sel;
    logic [CW-1:0]     lim_c;
    logic              full;
    logic              near;
    logic              clear_hit;
    logic signed [DATA_W:0] diff;
    logic [DATA_W:0]   mag;
    logic [63:0]       sq_c;
    logic [64:0]       dsum;
    logic [WDW-1:0]    tri_c;

    // slot of the i-th oldest pose
    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head,
                                              input logic [CW-1:0] idx);
        int tmp;
        tmp = int'(head) + int'(idx);
        if (tmp >= MAX_HISTORY)
        begin
            tmp = tmp - MAX_HISTORY;
        end
        return SW'(tmp);
    endfunction

    // handshakes
    assign s_row     = s_tuser[1:0];
    assign s_tracked = s_tuser[2];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = out_busy_reg && m_tready;

    // effective limit
    assign lim_c = (limit_reg == '0) ? CW'(1) :
                   (int'(limit_reg) > MAX_HISTORY) ? CW'(MAX_HISTORY) : CW'(limit_reg);

    // memory addressing
    assign full      = (int'(count_reg) >= MAX_HISTORY);
    assign issue     = (state_reg == ST_SUM) && (i_reg != count_reg);
    assign rd_slot   = slot_of(head_reg, i_reg);
    assign push_slot = full ? head_reg : slot_of(head_reg, count_reg);
    assign mem_raddr = AM'({rd_slot, e_reg});
    assign mem_waddr = AM'({push_slot, e_reg});
    assign mem_we    = (state_reg == ST_PUSH);

    // divider operands: round(s/d) = floor((2s + d) / 2d)
    assign den_sel   = wavg_reg ? wden_reg : WDW'(count_reg);
    assign div_num   = $signed({sacc_reg[AW-1], sacc_reg, 1'b0}) + $signed(NW'(den_sel));
    assign div_den   = {den_sel, 1'b0};
    assign div_start = (state_reg == ST_DIV_GO);

    // squared distance term
    assign diff  = $signed({incoming_reg[e_reg][DATA_W-1], incoming_reg[e_reg]})
                 - $signed({mean_reg[DATA_W-1], mean_reg});
    assign mag   = diff[DATA_W] ? DATA_W'(0) - diff : diff;
    assign sq_c  = mag[DATA_W-1:0] * mag[DATA_W-1:0];
    assign dsum  = {1'b0, dacc_reg} + {1'b0, sq_reg};
    assign near  = dacc_reg < {2'b00, thr2_reg};
    assign tri_c = WDW'(count_reg) * (WDW'(count_reg) + WDW'(1));

    assign clear_hit = ((jump_reg > CNT8_W'(1)) || (int'(lost_reg) > int'(lim_reg)))
                     && (count_reg != '0);

    phs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (incoming_reg[e_reg]),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    phs_div #(
        .NUM_W (NW),
        .DEN_W (MW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && (s_row == ROW_LAST))
                begin
                    if (!s_tracked)
                        state_next = ST_CLEAR;
                    else if (count_reg == '0)
                        state_next = ST_PUSH;
                    else
                        state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if ((i_reg == count_reg) && !v1_reg && !v2_reg)
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (!wavg_reg)
                        state_next = ST_SQ;
                    else if (e_reg == ELEM_LAST)
                        state_next = ST_CLEAR;
                    else
                        state_next = ST_SUM;
                end
            end
            ST_SQ:       state_next = ST_SQ_ACC;
            ST_SQ_ACC:   state_next = (e_reg == ELEM_LAST) ? ST_DECIDE : ST_SUM;
            ST_DECIDE:   state_next = near ? ST_PUSH : ST_TRIM;
            ST_PUSH:
            begin
                if (e_reg == ELEM_LAST)
                    state_next = first_reg ? ST_CLEAR : ST_TRIM;
            end
            ST_TRIM:     state_next = ST_WDEN;
            ST_WDEN:     state_next = ST_SUM;
            ST_CLEAR:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_busy_reg)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_W'(8);
            thr_reg      <= THR_W'(3 << FRAC_BITS);
            count_reg    <= '0;
            head_reg     <= '0;
            lost_reg     <= '0;
            jump_reg     <= '0;
            e_reg        <= '0;
            i_reg        <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            wavg_reg     <= 1'b0;
            first_reg    <= 1'b0;
            popped_reg   <= 1'b0;
            out_busy_reg <= 1'b0;
            out_row_reg  <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_HISTORY_LIMIT:  limit_reg <= cfg_data[LIMIT_W-1:0];
                    REG_JUMP_THRESHOLD: thr_reg   <= cfg_data;
                endcase
            end

            // read pipeline flags
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (issue)
            begin
                i_reg <= i_reg + 1'b1;
            end

            // result drain
            if (m_acc)
            begin
                out_row_reg <= out_row_reg + 1'b1;
                if (out_row_reg == ROW_LAST)
                    out_busy_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc && (s_row == ROW_LAST))
                    begin
                        e_reg     <= '0;
                        i_reg     <= '0;
                        wavg_reg  <= 1'b0;
                        first_reg <= s_tracked && (count_reg == '0);
                        if (s_tracked)
                            lost_reg <= '0;
                        else if (lost_reg != '1)
                            lost_reg <= lost_reg + 1'b1;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done && wavg_reg)
                    begin
                        e_reg <= e_reg + 1'b1;
                        i_reg <= '0;
                    end
                end
                ST_SQ_ACC:
                begin
                    e_reg <= e_reg + 1'b1;
                    i_reg <= '0;
                end
                ST_DECIDE:
                begin
                    e_reg <= '0;
                    if (near)
                    begin
                        jump_reg   <= '0;
                        popped_reg <= full;
                    end
                    else
                    begin
                        popped_reg <= 1'b0;
                        if (jump_reg != '1)
                            jump_reg <= jump_reg + 1'b1;
                    end
                end
                ST_PUSH:
                begin
                    e_reg <= e_reg + 1'b1;
                    if (e_reg == ELEM_LAST)
                    begin
                        if (full)
                            head_reg <= (int'(head_reg) == MAX_HISTORY - 1) ? '0
                                      : head_reg + 1'b1;
                        else
                            count_reg <= count_reg + 1'b1;
                    end
                end
                ST_TRIM:
                begin
                    if (!popped_reg && (count_reg > lim_reg))
                    begin
                        head_reg  <= (int'(head_reg) == MAX_HISTORY - 1) ? '0
                                   : head_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                ST_WDEN:
                begin
                    e_reg    <= '0;
                    i_reg    <= '0;
                    wavg_reg <= 1'b1;
                end
                ST_CLEAR:
                begin
                    if (clear_hit)
                    begin
                        count_reg <= '0;
                        head_reg  <= '0;
                        lost_reg  <= '0;
                        jump_reg  <= '0;
                    end
                end
                ST_DONE:
                begin
                    if (!out_busy_reg)
                    begin
                        out_busy_reg <= 1'b1;
                        out_row_reg  <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // held pose, zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < POSE_WORDS; k++)
                held_reg[k] <= '0;
        end
        else if ((state_reg == ST_PUSH) && (e_reg == ELEM_LAST) && first_reg)
        begin
            for (int k = 0; k < POSE_WORDS; k++)
                held_reg[k] <= incoming_reg[k];
        end
        else if ((state_reg == ST_DIV_WAIT) && div_done && wavg_reg)
        begin
            held_reg[e_reg] <= div_quot[DATA_W-1:0];
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        lim_reg  <= lim_c;
        thr2_reg <= thr_reg * thr_reg;

        // incoming rows
        if (s_acc)
        begin
            for (int c = 0; c < 4; c++)
                incoming_reg[{s_row, 2'(c)}] <= s_tdata[c*DATA_W +: DATA_W];
        end

        // weight rides along with the read
        if (issue)
            w1_reg <= wavg_reg ? CW'(int'(i_reg) + 1) : CW'(1);
        if (v1_reg)
            prod_reg <= $signed(mem_rdata) * $signed({1'b0, w1_reg});

        // per element sum
        if ((state_reg == ST_IDLE) || (state_reg == ST_SQ_ACC) || (state_reg == ST_WDEN)
            || ((state_reg == ST_DIV_WAIT) && div_done))
            sacc_reg <= '0;
        else if (v2_reg)
            sacc_reg <= sacc_reg + AW'(prod_reg);

        if ((state_reg == ST_DIV_WAIT) && div_done && !wavg_reg)
            mean_reg <= div_quot[DATA_W-1:0];

        // squared distance, saturating
        if (state_reg == ST_IDLE)
            dacc_reg <= '0;
        else if (state_reg == ST_SQ_ACC)
            dacc_reg <= dsum[64] ? '1 : dsum[63:0];
        if (state_reg == ST_SQ)
            sq_reg <= sq_c;

        if (state_reg == ST_WDEN)
            wden_reg <= tri_c >> 1;

        // result copy
        if ((state_reg == ST_DONE) && !out_busy_reg)
        begin
            for (int k = 0; k < POSE_WORDS; k++)
                out_pose_reg[k] <= held_reg[k];
            fill_reg <= FILL_W'(count_reg);
        end
    end

    // result ports
    assign m_tvalid = out_busy_reg;
    assign m_tuser  = out_row_reg;
    assign m_tlast  = (out_row_reg == ROW_LAST);
    assign m_tdata  = {3'b000, fill_reg,
                       out_pose_reg[{out_row_reg, 2'd3}],
                       out_pose_reg[{out_row_reg, 2'd2}],
                       out_pose_reg[{out_row_reg, 2'd1}],
                       out_pose_reg[{out_row_reg, 2'd0}]};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_HISTORY)
        else $error("history count beyond depth");

    a_jump_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && (count_reg != '0)) |-> (jump_reg <= CNT8_W'(1)))
        else $error("jump count not cleared");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule

// File: hw/rtl/phs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module phs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/phs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_div
// Iterative restoring divider giving floor(num / den) for signed num and
// positive den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phs_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] a_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic signed [NUM_W-1:0] quot_reg;

    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   rem_sub;
    logic [NUM_W-1:0] q_step;
    logic [NUM_W-1:0] a_start;

    // floor for negative num: -floor((-num + den - 1) / den), with -num-1 = ~num
    assign a_start = num[NUM_W-1] ? (~num + NUM_W'(den)) : num;

    // one restoring step
    assign shifted = {rem_reg, a_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign rem_sub = ge ? (shifted - {1'b0, den_reg}) : shifted;
    assign q_step  = {q_reg[NUM_W-2:0], ge};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_start;
            q_reg   <= '0;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            a_reg   <= {a_reg[NUM_W-2:0], 1'b0};
            q_reg   <= q_step;
            rem_reg <= rem_sub[DEN_W-1:0];
            if (cnt_reg == '0)
            begin
                quot_reg <= neg_reg ? -$signed(q_step) : $signed(q_step);
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: tb/sv/pose_smoother_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_smoother_checker
// Watches the row streams and the register port of the pose history
// stabilizer, predicts every stabilized pose row and compares it field by
// field with what the block emits.
// ----------------------------------------------------------------------------
module pose_smoother_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,    // elem_c0, elem_c1, elem_c2, elem_c3
    input  logic [2:0]   s_tuser,    // row_index[1:0], tracked
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,    // out_c0, out_c1, out_c2, out_c3, history_fill, pad
    input  logic [1:0]   m_tuser,    // out_row
    input  logic         m_tlast,    // last_row
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_data,
    output int           errors,
    output int           pending
);
    import phs_pkg::*;

    localparam int DEPTH = DEF_MAX_HISTORY;
    localparam int PRED_DEPTH = 16;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] col [4];
        logic        last;
        logic [4:0]  fill;
    } pose_row_t;

    // ring of predicted result items
    pose_row_t   smoothed_rows [PRED_DEPTH];
    int unsigned wr_cnt, rd_cnt;

    // predictor state
    int          hist [DEPTH][POSE_WORDS];
    int          incoming [POSE_WORDS];
    int          held [POSE_WORDS];
    int unsigned fill_cnt, head, lost, jumps;
    logic [4:0]  limit_reg;
    logic [30:0] thr_reg;

    assign pending = int'(wr_cnt - rd_cnt);

    // round to nearest, ties toward plus infinity
    function automatic longint div_nearest(longint s, longint d);
        longint n, m, q;
        n = 2 * s + d;
        m = 2 * d;
        q = n / m;
        if ((n % m) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic int unsigned clamped_limit();
        int unsigned l;
        l = limit_reg;
        if (l < 1)
            l = 1;
        if (l > DEPTH)
            l = DEPTH;
        return l;
    endfunction

    function automatic int unsigned slot(int unsigned i);
        return (head + i) % DEPTH;
    endfunction

    task automatic store_incoming();
        if (fill_cnt >= DEPTH)
        begin
            hist[head] = incoming;
            head = (head + 1) % DEPTH;
        end
        else
        begin
            hist[slot(fill_cnt)] = incoming;
            fill_cnt++;
        end
    endtask

    // squared frobenius distance to the history mean against threshold squared
    function automatic bit near_mean();
        logic [63:0] acc, sq, mag, t;
        longint sum, mean, diff;
        acc = 0;
        t = thr_reg;
        for (int e = 0; e < POSE_WORDS; e++)
        begin
            sum = 0;
            for (int unsigned i = 0; i < fill_cnt; i++)
                sum += hist[slot(i)][e];
            mean = div_nearest(sum, fill_cnt);
            diff = longint'(incoming[e]) - mean;
            mag = (diff < 0) ? -diff : diff;
            sq = mag * mag;
            if (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq)
                acc = 64'hFFFF_FFFF_FFFF_FFFF;
            else
                acc += sq;
        end
        return acc < t * t;
    endfunction

    task automatic weigh_history();
        longint n, den, sum;
        n = fill_cnt;
        den = n * (n + 1) / 2;
        if (n == 0)
            return;
        for (int e = 0; e < POSE_WORDS; e++)
        begin
            sum = 0;
            for (int unsigned i = 0; i < fill_cnt; i++)
                sum += longint'(hist[slot(i)][e]) * longint'(i + 1);
            held[e] = int'(div_nearest(sum, den));
        end
    endtask

    task automatic close_frame(bit trk);
        int unsigned lim;
        bit was_full, dropped;
        lim = clamped_limit();
        if (trk)
        begin
            lost = 0;
            if (fill_cnt == 0)
            begin
                store_incoming();
                held = incoming;
            end
            else
            begin
                was_full = fill_cnt >= DEPTH;
                dropped = 0;
                if (near_mean())
                begin
                    jumps = 0;
                    store_incoming();
                    dropped = was_full;
                end
                else if (jumps < 255)
                    jumps++;
                if (!dropped && fill_cnt > lim)
                begin
                    head = (head + 1) % DEPTH;
                    fill_cnt--;
                end
                weigh_history();
            end
        end
        else if (lost < 255)
            lost++;
        // too many jumps or lost frames empty the history
        if ((jumps > 1 || lost > lim) && fill_cnt != 0)
        begin
            fill_cnt = 0;
            head = 0;
            lost = 0;
            jumps = 0;
        end
    endtask

    // input item and register side
    always @(posedge clk or negedge rst_n)
    begin
        pose_row_t r;
        int unsigned rw;
        if (!rst_n)
        begin
            limit_reg = 5'd8;
            thr_reg = 31'(3 << DEF_FRAC_BITS);
            fill_cnt = 0;
            head = 0;
            lost = 0;
            jumps = 0;
            for (int e = 0; e < POSE_WORDS; e++)
            begin
                held[e] = 0;
                incoming[e] = 0;
            end
            wr_cnt = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_HISTORY_LIMIT)
                    limit_reg = cfg_data[4:0];
                else
                    thr_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                rw = s_tuser[1:0];
                for (int c = 0; c < 4; c++)
                    incoming[rw * 4 + c] = s_tdata[32 * c +: 32];
                if (s_tuser[1:0] == ROW_LAST)
                begin
                    close_frame(s_tuser[2]);
                    for (int k = 0; k < 4; k++)
                    begin
                        r.row = 2'(k);
                        for (int c = 0; c < 4; c++)
                            r.col[c] = held[k * 4 + c];
                        r.last = (k == 3);
                        r.fill = fill_cnt[4:0];
                        smoothed_rows[wr_cnt % PRED_DEPTH] = r;
                        wr_cnt++;
                    end
                end
            end
        end
    end

    // result item side
    always @(posedge clk or negedge rst_n)
    begin
        pose_row_t want;
        if (!rst_n)
        begin
            errors = 0;
            rd_cnt = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (wr_cnt == rd_cnt)
            begin
                $display("%0t: result row %0d with none expected", $time, m_tuser);
                errors++;
            end
            else
            begin
                want = smoothed_rows[rd_cnt % PRED_DEPTH];
                rd_cnt++;
                if (m_tuser !== want.row)
                begin
                    $display("%0t: out_row expected %0d got %0d", $time, want.row, m_tuser);
                    errors++;
                end
                for (int c = 0; c < 4; c++)
                    if (m_tdata[32 * c +: 32] !== want.col[c])
                    begin
                        $display("%0t: row %0d col %0d expected %h got %h", $time,
                                 want.row, c, want.col[c], m_tdata[32 * c +: 32]);
                        errors++;
                    end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_row expected %b got %b", $time, want.last, m_tlast);
                    errors++;
                end
                if (m_tdata[132:128] !== want.fill)
                begin
                    $display("%0t: history_fill expected %0d got %0d", $time,
                             want.fill, m_tdata[132:128]);
                    errors++;
                end
            end
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pose frames and register settings into the pose history
// stabilizer under random idling and a long output stall; the checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
    import phs_pkg::*;

    localparam int STALL_LIMIT = 30000;
    localparam int ONE = 1 << DEF_FRAC_BITS;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // elem_c0, elem_c1, elem_c2, elem_c3
    logic [2:0]   s_tuser;    // row_index[1:0], tracked
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;    // out_c0, out_c1, out_c2, out_c3, history_fill, pad
    logic [1:0]   m_tuser;    // out_row
    logic         m_tlast;
    logic         cfg_wr_en;
    logic         cfg_index;
    logic [30:0]  cfg_data;

    int errors, pending, items_sent, quiet_cycles;
    bit calm, hold_req;
    int hold_left;
    int base_pose [POSE_WORDS];

    pose_history_stabilizer dut (.*);

    pose_smoother_checker checker_i (.*);

    // clock
    initial clk = 0;
    always #5 clk = ~clk;

    // receiver with random idling and one long hold-off
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 0;
        end
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 19);
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("pose_history_stabilizer verification failed");
            $finish;
        end
    end

    task automatic send_row(logic [1:0] row, bit trk, int c0, int c1, int c2, int c3);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            s_tvalid = 0;
            @(negedge clk);
        end
        s_tvalid = 1;
        s_tuser = {trk, row};
        s_tdata = {c3, c2, c1, c0};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (items_sent == 60)
            hold_req = 1;
        @(negedge clk);
        s_tvalid = 0;
    endtask

    task automatic send_same(bit trk, int v);
        for (int r = 0; r < 4; r++)
            send_row(2'(r), trk, v, v, v, v);
    endtask

    // base pose plus noise of the given spread on every element
    task automatic send_noisy(bit trk, int spread);
        int v [4];
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
                v[c] = base_pose[r * 4 + c] + int'($urandom_range(0, 2 * spread)) - spread;
            send_row(2'(r), trk, v[0], v[1], v[2], v[3]);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_data = 31'(val);
        @(negedge clk);
        cfg_wr_en = 0;
    endtask

    initial
    begin
        int spread, pick, lim_v, thr_v;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_index = REG_HISTORY_LIMIT;
        cfg_data = '0;
        calm = 0;
        hold_req = 0;
        hold_left = 0;
        items_sent = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: full scale poses, jumps, lost frames, broken row order
        send_same(1, 32'sh7FFF_FFFF);
        send_same(1, 32'sh8000_0000);
        send_same(0, 32'sh8000_0000);
        send_same(1, 32'sh8000_0000);
        send_row(2, 1, -1, 0, 1, ONE);
        send_row(0, 0, ONE, -ONE, 7, 0);
        send_row(3, 1, 0, 0, 0, ONE);
        send_row(3, 0, 0, 0, 0, ONE);
        send_row(3, 1, 1, 2, 3, ONE);
        wait_drained();

        // register settings across the range, extremes included
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    lim_v = 1;
                    thr_v = 0;
                end
                1:
                begin
                    lim_v = 16;
                    thr_v = 32'h7FFF_FFFF;
                end
                2:
                begin
                    lim_v = 0;
                    thr_v = 3 * ONE;
                end
                3:
                begin
                    lim_v = 31;
                    thr_v = 20 * ONE;
                end
                4:
                begin
                    lim_v = 3;
                    thr_v = ONE / 2;
                end
                5:
                begin
                    lim_v = 8;
                    thr_v = 3 * ONE;
                end
                default:
                begin
                    lim_v = 16;
                    thr_v = 8 * ONE;
                end
            endcase
            write_reg(REG_HISTORY_LIMIT, lim_v);
            write_reg(REG_JUMP_THRESHOLD, thr_v);
            calm = (ph == 5);
            for (int e = 0; e < POSE_WORDS; e++)
                base_pose[e] = ((e % 5) == 0 ? ONE : 0) + int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
            for (int f = 0; f < 6; f++)
            begin
                pick = $urandom_range(0, 99);
                spread = (pick < 40) ? 300 : (pick < 70) ? ONE / 2 : (pick < 85) ? 4 * ONE : 0;
                if (pick < 88)
                    send_noisy(1, spread);
                else if (pick < 94)
                    send_noisy(0, spread);
                else
                    send_row(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             int'($urandom), int'($urandom), int'($urandom), int'($urandom));
            end
            wait_drained();
        end
        calm = 0;

        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("pose_history_stabilizer verification clean");
        else
            $display("pose_history_stabilizer verification failed");
        $finish;
    end

endmodule
